@@ rtl/core/pressure_temperature_compensation_unit_assert.svh @@
// assertion macros for the pressure/temperature compensation unit
// no dependencies; taken in by the top level with an include
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_UNIT_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptc assertion failed");
`define PTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptc assertion failed");
`else
`define PTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/ptc_pkg.sv @@
// shared types, constants and helpers of the compensation unit
// no dependencies
package ptc_pkg;

  localparam int TEMP_MIN    = -4000;
  localparam int TEMP_MAX    = 8500;
  localparam int PRESS_MAX   = 33554431;
  localparam int FINE_OFFSET = 128000;
  localparam int NUM_SCALE   = 3125;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_TRIM  = 3'd0,
    REG_PRESS_LOW  = 3'd1,
    REG_PRESS_MID  = 3'd2,
    REG_PRESS_HIGH = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } ptc_trim_t;

  typedef struct packed {
    logic signed [24:0] fine;
    logic signed [14:0] temp;
    logic        [19:0] raw_p;
  } ptc_fine_t;

  typedef struct packed {
    logic        [63:0] num;
    logic signed [30:0] den;
    logic signed [14:0] temp;
  } ptc_frac_t;

  typedef struct packed {
    logic        [63:0] quot;
    logic               inv;
    logic signed [14:0] temp;
  } ptc_quot_t;

  typedef struct packed {
    logic signed [14:0] temp;
    logic        [24:0] press;
    logic               inv;
  } ptc_result_t;

  // low 64 bits of a 64 x 16 product from its two 32-bit halves
  function automatic logic [63:0] join_parts(input logic signed [48:0] lo,
                                             input logic [31:0] hi);
    return {{15{lo[48]}}, lo} + {hi, 32'd0};
  endfunction

endpackage

@@ rtl/core/ptc_in_if.sv @@
// input channel: raw temperature and pressure beat
// no dependencies
interface ptc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;

  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

@@ rtl/core/ptc_out_if.sv @@
// output channel: compensated temperature and pressure beat
// no dependencies
interface ptc_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature_centi;
  logic        [24:0] pressure_q24_8;
  logic               pressure_invalid;

  modport source (output valid, temperature_centi, pressure_q24_8, pressure_invalid,
                  input ready);
  modport sink (input valid, temperature_centi, pressure_q24_8, pressure_invalid,
                output ready);
endinterface

@@ rtl/core/ptc_temp.sv @@
// temperature compensation: four stages, produces fine value and temperature
// depends on ptc_pkg
module ptc_temp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [19:0]         raw_t_i,
  input  logic [19:0]         raw_p_i,
  input  ptc_pkg::ptc_trim_t  trim_i,
  output logic                valid_o,
  output ptc_pkg::ptc_fine_t  data_o
);
  import ptc_pkg::*;

  logic [3:0]         v_q;
  logic signed [17:0] x;
  logic signed [16:0] d;
  logic signed [33:0] xa_d, xa_q;
  logic signed [33:0] dd_d;
  logic [32:0]        dd_q;
  logic [19:0]        rp1_q, rp2_q, rp3_q, rp4_q;
  logic signed [22:0] a_d, a_q;
  logic signed [37:0] eb_d, eb_q;
  logic signed [24:0] fine_d, fine3_q, fine4_q;
  logic signed [26:0] t5;
  logic signed [18:0] tsh;
  logic signed [14:0] temp_d, temp_q;

  assign x    = $signed({1'b0, raw_t_i[19:3]}) - $signed({1'b0, trim_i.t1, 1'b0});
  assign d    = $signed({1'b0, raw_t_i[19:4]}) - $signed({1'b0, trim_i.t1});
  assign xa_d = x * trim_i.t2;
  assign dd_d = d * d;

  assign a_d  = 23'(xa_q >>> 11);
  assign eb_d = $signed({1'b0, dd_q[32:12]}) * trim_i.t3;

  assign fine_d = 25'(a_q) + 25'(eb_q >>> 14);

  // fine * 5 + 128, then scale down
  assign t5  = (27'(fine3_q) <<< 2) + 27'(fine3_q) + 27'sd128;
  assign tsh = 19'(t5 >>> 8);

  always_comb begin
    priority if (tsh < 19'(TEMP_MIN)) begin
      temp_d = 15'(TEMP_MIN);
    end else if (tsh > 19'(TEMP_MAX)) begin
      temp_d = 15'(TEMP_MAX);
    end else begin
      temp_d = 15'(tsh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xa_q    <= xa_d;
      dd_q    <= dd_d[32:0];
      rp1_q   <= raw_p_i;
      a_q     <= a_d;
      eb_q    <= eb_d;
      rp2_q   <= rp1_q;
      fine3_q <= fine_d;
      rp3_q   <= rp2_q;
      fine4_q <= fine3_q;
      temp_q  <= temp_d;
      rp4_q   <= rp3_q;
    end
  end

  assign valid_o = v_q[3];
  always_comb begin
    data_o.fine  = fine4_q;
    data_o.temp  = temp_q;
    data_o.raw_p = rp4_q;
  end

endmodule

@@ rtl/core/ptc_pre.sv @@
// pressure front end: seven stages, builds the divider numerator and divisor
// depends on ptc_pkg
module ptc_pre (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  ptc_pkg::ptc_fine_t  data_i,
  input  ptc_pkg::ptc_trim_t  trim_i,
  output logic                valid_o,
  output ptc_pkg::ptc_frac_t  data_o
);
  import ptc_pkg::*;

  logic [6:0]         v_q;
  // stage 1
  logic signed [25:0] a0;
  logic signed [51:0] sq_d;
  logic [50:0]        sq_q;
  logic signed [41:0] m5_d, m5_q, m5b_q, m5c_q, m2_d, m2_q, m2b_q, m2c_q;
  // stage 2
  logic signed [48:0] lo6_d, lo6_q, lo3_d, lo3_q;
  logic [31:0]        hi6_d, hi6_q, hi3_d, hi3_q;
  // stage 3
  logic [63:0]        b6_q, b3_q;
  // stage 4
  logic [63:0]        b_d, b_q, x_d, x_q;
  // stage 5
  logic [47:0]        xl_d, xl_q;
  logic [31:0]        xh_d, xh_q;
  logic [20:0]        pp;
  logic [63:0]        n0_d, n0_q;
  // stage 6
  logic [63:0]        xp;
  logic signed [30:0] den_d, den_q, den7_q;
  logic [43:0]        nlo_d, nlo_q;
  logic [31:0]        nhi_d, nhi_q;
  // stage 7
  logic [63:0]        num_q;
  logic signed [14:0] tmp_q [7];
  logic [19:0]        rp_q [4];

  assign a0   = 26'(data_i.fine) - 26'(FINE_OFFSET);
  assign sq_d = a0 * a0;
  assign m5_d = a0 * trim_i.p5;
  assign m2_d = a0 * trim_i.p2;

  // square times p6 and p3, split into 32-bit halves
  assign lo6_d = $signed({1'b0, sq_q[31:0]}) * trim_i.p6;
  assign hi6_d = 32'({13'd0, sq_q[50:32]} * {{16{trim_i.p6[15]}}, trim_i.p6});
  assign lo3_d = $signed({1'b0, sq_q[31:0]}) * trim_i.p3;
  assign hi3_d = 32'({13'd0, sq_q[50:32]} * {{16{trim_i.p3[15]}}, trim_i.p3});

  assign b_d = b6_q + (64'(m5c_q) << 17) + (64'(trim_i.p4) << 35);
  assign x_d = 64'($signed(b3_q) >>> 8) + (64'(m2c_q) << 12) + (64'd1 << 47);

  assign xl_d = x_q[31:0] * trim_i.p1;
  assign xh_d = 32'(x_q[63:32] * {16'd0, trim_i.p1});
  assign pp   = 21'h100000 - {1'b0, rp_q[3]};
  assign n0_d = ({43'd0, pp} << 31) - b_q;

  assign xp    = {16'd0, xl_q} + {xh_q, 32'd0};
  assign den_d = 31'($signed(xp) >>> 33);
  assign nlo_d = n0_q[31:0] * 12'(NUM_SCALE);
  assign nhi_d = 32'(n0_q[63:32] * 32'(NUM_SCALE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q   <= sq_d[50:0];
      m5_q   <= m5_d;
      m2_q   <= m2_d;
      lo6_q  <= lo6_d;
      hi6_q  <= hi6_d;
      lo3_q  <= lo3_d;
      hi3_q  <= hi3_d;
      m5b_q  <= m5_q;
      m2b_q  <= m2_q;
      m5c_q  <= m5b_q;
      m2c_q  <= m2b_q;
      b6_q   <= join_parts(lo6_q, hi6_q);
      b3_q   <= join_parts(lo3_q, hi3_q);
      b_q    <= b_d;
      x_q    <= x_d;
      xl_q   <= xl_d;
      xh_q   <= xh_d;
      n0_q   <= n0_d;
      den_q  <= den_d;
      nlo_q  <= nlo_d;
      nhi_q  <= nhi_d;
      num_q  <= {20'd0, nlo_q} + {nhi_q, 32'd0};
      den7_q <= den_q;
      tmp_q[0] <= data_i.temp;
      rp_q[0]  <= data_i.raw_p;
      for (int i = 1; i < 7; i++) begin
        tmp_q[i] <= tmp_q[i-1];
      end
      for (int i = 1; i < 4; i++) begin
        rp_q[i] <= rp_q[i-1];
      end
    end
  end

  assign valid_o = v_q[6];
  always_comb begin
    data_o.num  = num_q;
    data_o.den  = den7_q;
    data_o.temp = tmp_q[6];
  end

endmodule

@@ rtl/core/ptc_div.sv @@
// signed 64 / 31-bit divider, one quotient bit per stage, truncating
// depends on ptc_pkg
module ptc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  ptc_pkg::ptc_frac_t  data_i,
  output logic                valid_o,
  output ptc_pkg::ptc_quot_t  data_o
);
  import ptc_pkg::*;

  localparam int DivBits = 64;
  localparam int DenW    = 31;
  localparam int RemW    = 30;

  typedef struct packed {
    logic [RemW-1:0]    rem;
    logic [DivBits-1:0] word;
    logic [DenW-1:0]    dvs;
    logic               neg;
    logic               inv;
    logic signed [14:0] temp;
  } div_stage_t;

  div_stage_t         st_q [DivBits+1];
  logic [DivBits+1:0] v_q;
  ptc_quot_t          res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DivBits:0], valid_i};
    end
  end

  // operands to magnitudes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].rem  <= '0;
      st_q[0].word <= data_i.num[DivBits-1] ? (DivBits'(0) - data_i.num) : data_i.num;
      st_q[0].dvs  <= data_i.den[DenW-1] ? (DenW'(0) - DenW'(data_i.den)) : DenW'(data_i.den);
      st_q[0].neg  <= data_i.num[DivBits-1] ^ data_i.den[DenW-1];
      st_q[0].inv  <= (data_i.den == '0);
      st_q[0].temp <= data_i.temp;
    end
  end

  for (genvar i = 0; i < DivBits; i++) begin : g_step
    logic [DenW-1:0] trial;
    logic            ge;
    logic [RemW-1:0] rem_d;

    assign trial = {st_q[i].rem, st_q[i].word[DivBits-1]};
    assign ge    = (trial >= st_q[i].dvs);
    assign rem_d = ge ? RemW'(trial - st_q[i].dvs) : trial[RemW-1:0];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i+1].rem  <= rem_d;
        st_q[i+1].word <= {st_q[i].word[DivBits-2:0], ge};
        st_q[i+1].dvs  <= st_q[i].dvs;
        st_q[i+1].neg  <= st_q[i].neg;
        st_q[i+1].inv  <= st_q[i].inv;
        st_q[i+1].temp <= st_q[i].temp;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.quot <= st_q[DivBits].neg ? (DivBits'(0) - st_q[DivBits].word)
                                      : st_q[DivBits].word;
      res_q.inv  <= st_q[DivBits].inv;
      res_q.temp <= st_q[DivBits].temp;
    end
  end

  assign valid_o = v_q[DivBits+1];
  assign data_o  = res_q;

endmodule

@@ rtl/core/ptc_post.sv @@
// pressure back end: six stages of trim corrections and saturation
// depends on ptc_pkg
module ptc_post (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  ptc_pkg::ptc_quot_t   data_i,
  input  ptc_pkg::ptc_trim_t   trim_i,
  output logic                 valid_o,
  output ptc_pkg::ptc_result_t data_o
);
  import ptc_pkg::*;

  logic [5:0]         v_q;
  logic signed [50:0] s;
  logic [63:0]        mll_d, mll_q;
  logic [31:0]        mlh_d, mlh_q;
  logic signed [48:0] p8lo_d, p8lo_q, lo9_d, lo9_q;
  logic [31:0]        p8hi_d, p8hi_q, hi9_d, hi9_q;
  logic [63:0]        ss_q, bq_q, b3_d, b3_q, b3b_q, a3_d, a3_q, sum_q;
  logic [63:0]        q_q [4];
  logic               inv_q [6];
  logic signed [14:0] tmp_q [6];
  logic signed [63:0] pr;
  logic [24:0]        press_d, press_q;

  // square of (q >>> 13), low 64 bits from 32-bit halves
  assign s      = 51'($signed(data_i.quot) >>> 13);
  assign mll_d  = s[31:0] * s[31:0];
  assign mlh_d  = 32'(s[31:0] * {{13{s[50]}}, s[50:32]});
  assign p8lo_d = $signed({1'b0, data_i.quot[31:0]}) * trim_i.p8;
  assign p8hi_d = 32'(data_i.quot[63:32] * {{16{trim_i.p8[15]}}, trim_i.p8});

  assign lo9_d = $signed({1'b0, ss_q[31:0]}) * trim_i.p9;
  assign hi9_d = 32'(ss_q[63:32] * {{16{trim_i.p9[15]}}, trim_i.p9});
  assign b3_d  = 64'($signed(bq_q) >>> 19);

  assign a3_d = 64'($signed(join_parts(lo9_q, hi9_q)) >>> 25);

  assign pr = ($signed(sum_q) >>> 8) + (64'(trim_i.p7) <<< 4);

  always_comb begin
    priority if (inv_q[4]) begin
      press_d = '0;
    end else if (pr < 64'sd0) begin
      press_d = '0;
    end else if (pr > 64'(PRESS_MAX)) begin
      press_d = 25'(PRESS_MAX);
    end else begin
      press_d = pr[24:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mll_q   <= mll_d;
      mlh_q   <= mlh_d;
      p8lo_q  <= p8lo_d;
      p8hi_q  <= p8hi_d;
      ss_q    <= mll_q + {mlh_q[30:0], 33'd0};
      bq_q    <= join_parts(p8lo_q, p8hi_q);
      lo9_q   <= lo9_d;
      hi9_q   <= hi9_d;
      b3_q    <= b3_d;
      a3_q    <= a3_d;
      b3b_q   <= b3_q;
      sum_q   <= q_q[3] + a3_q + b3b_q;
      press_q <= press_d;
      q_q[0]   <= data_i.quot;
      inv_q[0] <= data_i.inv;
      tmp_q[0] <= data_i.temp;
      for (int i = 1; i < 4; i++) begin
        q_q[i] <= q_q[i-1];
      end
      for (int i = 1; i < 6; i++) begin
        inv_q[i] <= inv_q[i-1];
        tmp_q[i] <= tmp_q[i-1];
      end
    end
  end

  assign valid_o = v_q[5];
  always_comb begin
    data_o.temp  = tmp_q[5];
    data_o.press = press_q;
    data_o.inv   = inv_q[5];
  end

endmodule

@@ rtl/core/pressure_temperature_compensation_unit.sv @@
// An input beat passes in order through the temperature stages, the pressure
// front end, the divider and the pressure back end; the divider's one quotient
// bit per stage sets the depth. Throughput: one beat per cycle while no output
// beat waits. The whole pipeline holds while an output beat waits. Reset clears
// all valid bits and the four trim registers to zero.
`include "pressure_temperature_compensation_unit_assert.svh"
module pressure_temperature_compensation_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  ptc_in_if.sink                           in_i,
  ptc_out_if.source                        out_o
);
  import ptc_pkg::*;

  logic [CFG_DATA_W-1:0] ttrim_q, plow_q, pmid_q, phigh_q;
  ptc_trim_t             trim;
  logic                  pipe_en;
  logic                  fine_valid, frac_valid, quot_valid, res_valid;
  ptc_fine_t             fine_data;
  ptc_frac_t             frac_data;
  ptc_quot_t             quot_data;
  ptc_result_t           res_data;
  logic                  temp_in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttrim_q <= '0;
      plow_q  <= '0;
      pmid_q  <= '0;
      phigh_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TEMP_TRIM:  ttrim_q <= cfg_data_i;
        REG_PRESS_LOW:  plow_q  <= cfg_data_i;
        REG_PRESS_MID:  pmid_q  <= cfg_data_i;
        REG_PRESS_HIGH: phigh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    trim.t1 = ttrim_q[15:0];
    trim.t2 = $signed(ttrim_q[31:16]);
    trim.t3 = $signed(ttrim_q[47:32]);
    trim.p1 = plow_q[15:0];
    trim.p2 = $signed(plow_q[31:16]);
    trim.p3 = $signed(plow_q[47:32]);
    trim.p4 = $signed(pmid_q[15:0]);
    trim.p5 = $signed(pmid_q[31:16]);
    trim.p6 = $signed(pmid_q[47:32]);
    trim.p7 = $signed(phigh_q[15:0]);
    trim.p8 = $signed(phigh_q[31:16]);
    trim.p9 = $signed(phigh_q[47:32]);
  end

  // the last stage register is the output register
  assign pipe_en    = out_o.ready || !res_valid;
  assign in_i.ready = pipe_en;

  ptc_temp u_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (in_i.valid),
    .raw_t_i (in_i.raw_temperature),
    .raw_p_i (in_i.raw_pressure),
    .trim_i  (trim),
    .valid_o (fine_valid),
    .data_o  (fine_data)
  );

  ptc_pre u_pre (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (fine_valid),
    .data_i  (fine_data),
    .trim_i  (trim),
    .valid_o (frac_valid),
    .data_o  (frac_data)
  );

  ptc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (frac_valid),
    .data_i  (frac_data),
    .valid_o (quot_valid),
    .data_o  (quot_data)
  );

  ptc_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (quot_valid),
    .data_i  (quot_data),
    .trim_i  (trim),
    .valid_o (res_valid),
    .data_o  (res_data)
  );

  assign out_o.valid             = res_valid;
  assign out_o.temperature_centi = res_data.temp;
  assign out_o.pressure_q24_8    = res_data.press;
  assign out_o.pressure_invalid  = res_data.inv;

  assign temp_in_range = ($signed(out_o.temperature_centi) >= 15'(TEMP_MIN)) &&
                         ($signed(out_o.temperature_centi) <= 15'(TEMP_MAX));

  `PTC_ASSERT_IMP(a_inv_zero, clk_i, rst_ni, out_o.valid && out_o.pressure_invalid, out_o.pressure_q24_8 == '0)
  `PTC_ASSERT_IMP(a_temp_range, clk_i, rst_ni, out_o.valid, temp_in_range)
  `PTC_ASSERT_IMP(a_stall_in, clk_i, rst_ni, out_o.valid && !out_o.ready, !in_i.ready)
  `PTC_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, !pipe_en, $stable(fine_valid) && $stable(quot_valid))

endmodule
